>>> src/multi_channel_watchdog_unit_defines.svh
// Assertion macros shared by the watchdog RTL.
// Uses the including module's clk and rst_n; no other dependencies.
`ifndef MULTI_CHANNEL_WATCHDOG_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_WATCHDOG_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset
`define MCW_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true outside reset
`define MCW_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MCW_ASSERT(name, prop, msg)
`define MCW_NEVER(name, cond, msg)
`endif

`endif

>>> src/mcw_pkg.sv
// Shared constants, codes and types of the multi-channel watchdog.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mcw_pkg;

    // Table size and derived widths
    localparam int CHANNELS  = 12;
    localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W     = $clog2(CHANNELS + 1);
    localparam int MASK_BITS = 12;
    localparam int CHAN_BITS = 4;
    localparam int TICK_W    = 32;
    localparam int ENTRY_W   = 2 * TICK_W;

    // Item kinds
    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_REG  = 2'd1,
        ACT_KICK = 2'd2
    } action_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_UNREG = 2'd2
    } stat_t;

    // One result item
    typedef struct packed {
        logic [MASK_BITS-1:0] expired_mask;
        logic [CHAN_BITS-1:0] assigned_channel;
        stat_t                status;
    } result_t;

endpackage

`default_nettype wire

>>> src/mcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mcw_ram #(
    parameter int DEPTH = 12,
    parameter int WIDTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/mcw_ctrl.sv
// Watchdog sequencer: register, kick and tick walk over the channel RAM.
// Depends on mcw_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_channel_watchdog_unit_defines.svh"

module mcw_ctrl (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Item side
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        action,
    input  wire logic [mcw_pkg::CHAN_BITS-1:0]     channel,
    input  wire logic [mcw_pkg::TICK_W-1:0]        timeout_ticks,
    // Result side
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output mcw_pkg::result_t                       res,
    // Channel RAM
    output logic                                   wr_en,
    output logic [mcw_pkg::IDX_W-1:0]              wr_addr,
    output logic [mcw_pkg::ENTRY_W-1:0]            wr_data,
    output logic                                   rd_en,
    output logic [mcw_pkg::IDX_W-1:0]              rd_addr,
    input  wire logic [mcw_pkg::ENTRY_W-1:0]       rd_data
);

    import mcw_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KICK,
        ST_TICK,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     in_use_reg, in_use_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [MASK_BITS-1:0] mask_reg, mask_next;
    logic [CHAN_BITS-1:0] assigned_reg, assigned_next;
    stat_t                status_reg, status_next;
    logic                 rd_pend_reg;

    logic [TICK_W-1:0]    rd_reload;
    logic [TICK_W-1:0]    rd_count;

    // RAM entry layout: reload value high, counter low
    assign rd_reload = rd_data[ENTRY_W-1:TICK_W];
    assign rd_count  = rd_data[TICK_W-1:0];

    // Sequencer next-state and RAM port control
    always_comb
    begin
        state_next    = state_reg;
        in_use_next   = in_use_reg;
        idx_next      = idx_reg;
        mask_next     = mask_reg;
        assigned_next = assigned_reg;
        status_next   = status_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = {rd_reload, rd_reload};
        rd_en         = 1'b0;
        rd_addr       = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mask_next     = '0;
                    assigned_next = '0;
                    status_next   = STAT_OK;
                    state_next    = ST_DONE;
                    unique case (action)
                        ACT_REG:
                        begin
                            if (32'(in_use_reg) < CHANNELS)
                            begin
                                wr_en         = 1'b1;
                                wr_addr       = IDX_W'(in_use_reg);
                                wr_data       = {timeout_ticks, timeout_ticks};
                                assigned_next = CHAN_BITS'(in_use_reg);
                                in_use_next   = CNT_W'(in_use_reg + 1'b1);
                            end
                            else
                            begin
                                status_next = STAT_FULL;
                            end
                        end
                        ACT_KICK:
                        begin
                            if (32'(channel) < 32'(in_use_reg))
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = IDX_W'(channel);
                                idx_next   = IDX_W'(channel);
                                state_next = ST_KICK;
                            end
                            else
                            begin
                                status_next = STAT_UNREG;
                            end
                        end
                        default:
                        begin
                            // tick, and the unused code behaves as a tick
                            if (in_use_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = ST_TICK;
                            end
                        end
                    endcase
                end
            end
            ST_KICK:
            begin
                // counter takes the reload value
                wr_en      = 1'b1;
                wr_data    = {rd_reload, rd_reload};
                state_next = ST_DONE;
            end
            ST_TICK:
            begin
                // write back entry idx while reading the next one
                wr_en = 1'b1;
                if (rd_count == '0)
                begin
                    wr_data = {rd_reload, rd_reload};
                    for (int b = 0; b < MASK_BITS; b++)
                    begin
                        if (32'(idx_reg) == b)
                        begin
                            mask_next[b] = 1'b1;
                        end
                    end
                end
                else
                begin
                    wr_data = {rd_reload, rd_count - 1'b1};
                end
                if (32'(idx_reg) + 1 < 32'(in_use_reg))
                begin
                    rd_en    = 1'b1;
                    rd_addr  = IDX_W'(idx_reg + 1'b1);
                    idx_next = IDX_W'(idx_reg + 1'b1);
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.expired_mask     = mask_reg;
    assign res.assigned_channel = assigned_reg;
    assign res.status           = status_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            in_use_reg  <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            in_use_reg  <= in_use_next;
            rd_pend_reg <= rd_en;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        mask_reg     <= mask_next;
        assigned_reg <= assigned_next;
        status_reg   <= status_next;
    end

    // Read and write never hit the same entry in one cycle
    `MCW_NEVER(a_no_rw_collide, rd_en && wr_en && (rd_addr == wr_addr), "RAM read/write collision")
    // Every write-back in kick or tick uses data read in the cycle before
    `MCW_ASSERT(a_rd_before_wb, (state_reg == ST_KICK || state_reg == ST_TICK) |-> rd_pend_reg, "write-back without read data")
    // The channel count only ever grows by one
    `MCW_ASSERT(a_in_use_step, (in_use_reg != $past(in_use_reg)) |-> (32'(in_use_reg) == 32'($past(in_use_reg)) + 1), "channel count jumped")
    // Table never holds more than its size
    `MCW_ASSERT(a_in_use_max, 32'(in_use_reg) <= CHANNELS, "channel count above table size")

endmodule

`default_nettype wire

>>> src/multi_channel_watchdog_unit.sv
// Register and rejected items go straight to the result; a kick reads its entry and writes it back,
// a tick walks all N registered channels (one RAM read and write-back per channel).
// Items are taken one at a time: the walk over the channel RAM and output back-pressure hold off the next.
// A new item is taken once the previous result sits in the output register.
// Reset clears the channel count and handshake state; RAM contents are not cleared.
// Top level: channel RAM, sequencer and output register. Depends on mcw_pkg, mcw_ram, mcw_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_watchdog_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // channel[3:0], timeout_ticks[35:4], zero[39:36]
    input  wire logic [1:0]  s_axis_tuser,   // action[1:0]
    // Output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // expired_mask[11:0], assigned_channel[15:12]
    output logic [1:0]       m_axis_tuser    // status[1:0]
);

    import mcw_pkg::*;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [ENTRY_W-1:0]   wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [ENTRY_W-1:0]   rd_data;

    logic                 res_valid;
    logic                 res_ready;
    result_t              res;

    logic                 out_valid_reg, out_valid_next;
    result_t              out_res_reg;

    // Channel table: reload value and counter per entry
    mcw_ram #(
        .DEPTH (CHANNELS),
        .WIDTH (ENTRY_W),
        .AW    (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mcw_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .action        (s_axis_tuser),
        .channel       (s_axis_tdata[CHAN_BITS-1:0]),
        .timeout_ticks (s_axis_tdata[CHAN_BITS+TICK_W-1:CHAN_BITS]),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    // Output register takes a result when empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.assigned_channel, out_res_reg.expired_mask};
    assign m_axis_tuser  = out_res_reg.status;

endmodule

`default_nettype wire
